@@ rtl/toni_pkg.sv @@
// ----------------------------------------------------------------------------
// toni_pkg
// Shared constants for the truncated-octahedron minimum image pipeline.
// ----------------------------------------------------------------------------
package toni_pkg;

   localparam int AXES = 3;
   localparam int BOX_WIDTH = 31;
   localparam logic [BOX_WIDTH-1:0] BOX_RESET = 31'd65536;

endpackage

@@ rtl/toni_wrap.sv @@
// ----------------------------------------------------------------------------
// toni_wrap
// Wraps three difference components into the box: restoring division of the
// magnitude by the edge, one quotient bit per stage, then floor correction
// and round-half-even selection of the wrapped component.
// ----------------------------------------------------------------------------
module toni_wrap #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [toni_pkg::AXES-1:0][COORD_WIDTH:0]      in_diff,
   input  logic [toni_pkg::AXES-1:0][COORD_WIDTH-1:0]    in_ref,
   input  logic [toni_pkg::BOX_WIDTH-1:0]                box_len,
   output logic                                          out_valid,
   output logic [toni_pkg::AXES-1:0][((COORD_WIDTH+1 > toni_pkg::BOX_WIDTH+1) ?
                 COORD_WIDTH+1 : toni_pkg::BOX_WIDTH+1)-1:0] out_wrap,
   output logic [toni_pkg::AXES-1:0][COORD_WIDTH-1:0]    out_ref
);

   localparam int W  = COORD_WIDTH;
   localparam int MW = COORD_WIDTH + 1;
   localparam int BW = toni_pkg::BOX_WIDTH;
   localparam int NA = toni_pkg::AXES;
   localparam int AW = (MW > BW + 1) ? MW : BW + 1;

   logic [MW:0]                 vld_ff;
   logic [NA-1:0][W:0]          diff_ff [0:MW];
   logic [NA-1:0][W-1:0]        ref_ff  [0:MW];
   logic [NA-1:0][MW-1:0]       dvd_ff  [0:MW-1];
   logic [NA-1:0][BW-1:0]       rem_ff  [0:MW];
   logic [NA-1:0]               qlsb_ff [1:MW];

   logic [NA-1:0][MW-1:0]       mag_in;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         mag_in[i] = in_diff[i][W] ? MW'(~in_diff[i] + 1'b1) : MW'(in_diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      diff_ff[0] <= in_diff;
      ref_ff[0]  <= in_ref;
      dvd_ff[0]  <= mag_in;
      rem_ff[0]  <= '0;
   end

   for (genvar k = 1; k <= MW; k++) begin : g_step
      logic [NA-1:0][BW:0] shift_w;
      logic [NA-1:0][BW:0] rem_in;
      logic [NA-1:0]       ge_w;

      always_comb begin
         for (int i = 0; i < NA; i++) begin
            shift_w[i] = {rem_ff[k-1][i], dvd_ff[k-1][i][MW-1]};
            ge_w[i]    = shift_w[i] >= {1'b0, box_len};
            rem_in[i]  = ge_w[i] ? shift_w[i] - {1'b0, box_len} : shift_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         diff_ff[k] <= diff_ff[k-1];
         ref_ff[k]  <= ref_ff[k-1];
         qlsb_ff[k] <= ge_w;
         for (int i = 0; i < NA; i++) begin
            rem_ff[k][i] <= rem_in[i][BW-1:0];
         end
      end

      if (k < MW) begin : g_dvd
         always_ff @(posedge clock) begin
            for (int i = 0; i < NA; i++) begin
               dvd_ff[k][i] <= {dvd_ff[k-1][i][MW-2:0], 1'b0};
            end
         end
      end
   end

   // floor correction for negative differences
   logic                  fx_vld_ff;
   logic [NA-1:0][BW-1:0] fx_rem_ff, fx_rem_in;
   logic [NA-1:0]         fx_odd_ff, fx_odd_in;
   logic [NA-1:0][W:0]    fx_diff_ff;
   logic [NA-1:0][W-1:0]  fx_ref_ff;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         if (diff_ff[MW][i][W] && (rem_ff[MW][i] != '0)) begin
            fx_rem_in[i] = box_len - rem_ff[MW][i];
            fx_odd_in[i] = ~qlsb_ff[MW][i];
         end else begin
            fx_rem_in[i] = rem_ff[MW][i];
            fx_odd_in[i] = qlsb_ff[MW][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_vld_ff <= 1'b0;
      end else begin
         fx_vld_ff <= vld_ff[MW];
      end
      fx_rem_ff  <= fx_rem_in;
      fx_odd_ff  <= fx_odd_in;
      fx_diff_ff <= diff_ff[MW];
      fx_ref_ff  <= ref_ff[MW];
   end

   // pick r or r - L, ties to even quotient
   logic                  wr_vld_ff;
   logic [NA-1:0][AW-1:0] wr_a_ff, wr_a_in;
   logic [NA-1:0][W-1:0]  wr_ref_ff;
   logic [NA-1:0][BW:0]   twice_w;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         twice_w[i] = {fx_rem_ff[i], 1'b0};
         if (box_len == '0) begin
            wr_a_in[i] = AW'($signed(fx_diff_ff[i]));
         end else if ((twice_w[i] < {1'b0, box_len}) ||
                      ((twice_w[i] == {1'b0, box_len}) && !fx_odd_ff[i])) begin
            wr_a_in[i] = AW'(fx_rem_ff[i]);
         end else begin
            wr_a_in[i] = AW'(fx_rem_ff[i]) - AW'(box_len);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= fx_vld_ff;
      end
      wr_a_ff   <= wr_a_in;
      wr_ref_ff <= fx_ref_ff;
   end

   assign out_valid = wr_vld_ff;
   assign out_wrap  = wr_a_ff;
   assign out_ref   = wr_ref_ff;

endmodule

@@ rtl/trunc_oct_nearest_image.sv @@
// ----------------------------------------------------------------------------
// trunc_oct_nearest_image
// Nearest periodic image of a second position in a truncated-octahedron box.
//
//   channel  ports            handshake
//   request  req_*            beat taken when start is high and busy is low
//   response rsp_*            one-cycle strobe rsp_valid, cannot be held off
//   config   csr_*            box_length written when csr_we is high
//
// One beat enters every cycle; busy stays low. The pipeline depth grows with
// COORD_WIDTH through the division pipeline, which retires one quotient bit per
// stage. Reset clears all valid bits and loads an edge of 65536; beats in
// flight are dropped.
// ----------------------------------------------------------------------------
module trunc_oct_nearest_image #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_ref_x,
   input  logic signed [COORD_WIDTH-1:0]        req_ref_y,
   input  logic signed [COORD_WIDTH-1:0]        req_ref_z,
   input  logic signed [COORD_WIDTH-1:0]        req_other_x,
   input  logic signed [COORD_WIDTH-1:0]        req_other_y,
   input  logic signed [COORD_WIDTH-1:0]        req_other_z,
   input  logic                                 csr_we,
   input  logic [toni_pkg::BOX_WIDTH-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   output logic signed [COORD_WIDTH-1:0]        rsp_image_x,
   output logic signed [COORD_WIDTH-1:0]        rsp_image_y,
   output logic signed [COORD_WIDTH-1:0]        rsp_image_z
);

   localparam int W  = COORD_WIDTH;
   localparam int BW = toni_pkg::BOX_WIDTH;
   localparam int NA = toni_pkg::AXES;
   localparam int AW = (W + 1 > BW + 1) ? W + 1 : BW + 1;
   localparam int SUMW = AW + 2;
   localparam int SW = AW + 4;
   localparam int TW = AW + 3;
   localparam int DEPTH = W + 9;
   localparam logic signed [TW-1:0] SAT_HI = TW'((longint'(1) <<< (W - 1)) - 1);
   localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

   logic [BW-1:0] box_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= toni_pkg::BOX_RESET;
      end else if (csr_we) begin
         box_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // input stage: differences
   logic                 in_vld_ff;
   logic [NA-1:0][W:0]   in_diff_ff;
   logic [NA-1:0][W-1:0] in_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_diff_ff[0] <= (W+1)'(req_other_x) - (W+1)'(req_ref_x);
      in_diff_ff[1] <= (W+1)'(req_other_y) - (W+1)'(req_ref_y);
      in_diff_ff[2] <= (W+1)'(req_other_z) - (W+1)'(req_ref_z);
      in_ref_ff[0]  <= req_ref_x;
      in_ref_ff[1]  <= req_ref_y;
      in_ref_ff[2]  <= req_ref_z;
   end

   logic                  wr_vld;
   logic [NA-1:0][AW-1:0] wr_a;
   logic [NA-1:0][W-1:0]  wr_ref;

   toni_wrap #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_vld_ff),
      .in_diff  (in_diff_ff),
      .in_ref   (in_ref_ff),
      .box_len  (box_ff),
      .out_valid(wr_vld),
      .out_wrap (wr_a),
      .out_ref  (wr_ref)
   );

   // sum of magnitudes
   logic                  sm_vld_ff;
   logic [SUMW-1:0]       sm_sum_ff, sm_sum_in;
   logic [NA-1:0][AW-1:0] sm_a_ff;
   logic [NA-1:0][W-1:0]  sm_ref_ff;
   logic [NA-1:0][AW-1:0] abs_w;

   always_comb begin
      sm_sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         abs_w[i]  = wr_a[i][AW-1] ? AW'(~wr_a[i] + 1'b1) : wr_a[i];
         sm_sum_in = sm_sum_in + SUMW'(abs_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else begin
         sm_vld_ff <= wr_vld;
      end
      sm_sum_ff <= sm_sum_in;
      sm_a_ff   <= wr_a;
      sm_ref_ff <= wr_ref;
   end

   // half-edge decision: 4*sum > 3*L
   logic                  hs_vld_ff;
   logic                  hs_shift_ff, hs_shift_in;
   logic [NA-1:0][AW-1:0] hs_a_ff;
   logic [NA-1:0][W-1:0]  hs_ref_ff;

   always_comb begin
      hs_shift_in = (box_ff != '0) &&
                    ((SW'(sm_sum_ff) << 2) > (SW'(box_ff) + (SW'(box_ff) << 1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_vld_ff <= 1'b0;
      end else begin
         hs_vld_ff <= sm_vld_ff;
      end
      hs_shift_ff <= hs_shift_in;
      hs_a_ff     <= sm_a_ff;
      hs_ref_ff   <= sm_ref_ff;
   end

   // doubled image: 2*ref + 2*a -/+ L
   logic                  db_vld_ff;
   logic [NA-1:0][TW-1:0] db_t_ff, db_t_in;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         db_t_in[i] = (TW'($signed(hs_ref_ff[i])) <<< 1) + (TW'($signed(hs_a_ff[i])) <<< 1);
         if (hs_shift_ff) begin
            if (hs_a_ff[i][AW-1]) begin
               db_t_in[i] = db_t_in[i] + TW'(box_ff);
            end else begin
               db_t_in[i] = db_t_in[i] - TW'(box_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_vld_ff <= 1'b0;
      end else begin
         db_vld_ff <= hs_vld_ff;
      end
      db_t_ff <= db_t_in;
   end

   // halve to nearest even, saturate
   logic                  out_vld_ff;
   logic [NA-1:0][W-1:0]  out_img_ff, out_img_in;
   logic signed [TW-1:0]  half_w [NA];

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         half_w[i] = ($signed(db_t_ff[i]) >>> 1) +
                     $signed(TW'(db_t_ff[i][0] & db_t_ff[i][1]));
         if (half_w[i] > SAT_HI) begin
            out_img_in[i] = SAT_HI[W-1:0];
         end else if (half_w[i] < SAT_LO) begin
            out_img_in[i] = SAT_LO[W-1:0];
         end else begin
            out_img_in[i] = half_w[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= db_vld_ff;
      end
      out_img_ff <= out_img_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_image_x = $signed(out_img_ff[0]);
   assign rsp_image_y = $signed(out_img_ff[1]);
   assign rsp_image_z = $signed(out_img_ff[2]);

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##DEPTH rsp_valid)
      else $error("accepted beat did not produce a result on time");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, DEPTH))
      else $error("result without a matching request beat");

   a_shift_needs_box : assert property (@(posedge clock) disable iff (reset)
      hs_shift_ff |-> (box_ff != '0))
      else $error("half-edge step taken with zero edge");
`endif

endmodule
